[design/lpht_pkg.sv]
package lpht_pkg;
   localparam int MAX_SLOTS_DEF   = 1024;
   localparam int KEY_BYTES_DEF   = 8;
   localparam int VALUE_BYTES_DEF = 8;
   localparam int CAP_W    = 11;
   localparam int DCAP_W   = 15;
   localparam int OP_W     = 2;
   localparam int KEYC_W   = 64;
   localparam int KLEN_W   = 4;
   localparam int VAL_W    = 64;
   localparam int ST_W     = 2;
   localparam int SLOT_W   = 10;
   localparam int HASH_W   = 32;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

   localparam logic [ST_W-1:0] ST_OK         = 2'd0;
   localparam logic [ST_W-1:0] ST_NOT_FOUND  = 2'd1;
   localparam logic [ST_W-1:0] ST_INDEX_FULL = 2'd2;
   localparam logic [ST_W-1:0] ST_DATA_FULL  = 2'd3;

   localparam logic CSR_INDEX_CAP = 1'b0;
   localparam logic CSR_DATA_CAP  = 1'b1;

   typedef struct packed {
      logic load;
      logic hash_step;
      logic mod_start;
      logic rd_issue;
      logic advance;
      logic write_slot;
      logic clr_start;
      logic respond;
      logic [ST_W-1:0] status;
      logic with_value;
      logic with_slot;
   } cmd_type;

   typedef struct packed {
      logic       is_insert;
      logic       is_lookup;
      logic       is_clear;
      logic       hash_done;
      logic       mod_done;
      logic       clr_done;
      logic       slot_empty;
      logic       slot_match;
      logic       circle_done;
      logic       data_full;
   } sts_type;
endpackage

[design/lpht_ram.sv]
module lpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

[design/lpht_ctrl.sv]
module lpht_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output lpht_pkg::cmd_type cmd,
   input  lpht_pkg::sts_type sts
);
   import lpht_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_HASH  = 3'd1;
   localparam logic [2:0] S_MOD   = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_CHECK = 3'd4;
   localparam logic [2:0] S_CLEAR = 3'd5;

   logic [2:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      busy = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (sts.is_clear) begin
               cmd.clr_start = 1'b1;
               cmd.respond = 1'b1;
               cmd.status = ST_OK;
               state_in = S_CLEAR;
            end else if (!sts.is_insert && !sts.is_lookup) begin
               cmd.respond = 1'b1;
               cmd.status = ST_OK;
               state_in = S_IDLE;
            end else if (sts.hash_done) begin
               cmd.mod_start = 1'b1;
               state_in = S_MOD;
            end else begin
               cmd.hash_step = 1'b1;
            end
         end
         S_MOD: begin
            if (sts.mod_done) begin
               cmd.rd_issue = 1'b1;
               state_in = S_READ;
            end
         end
         S_READ: state_in = S_CHECK;
         S_CHECK: begin
            if (sts.slot_match) begin
               cmd.respond = 1'b1;
               cmd.status = ST_OK;
               cmd.with_slot = 1'b1;
               cmd.with_value = sts.is_lookup;
               cmd.write_slot = sts.is_insert;
               state_in = S_IDLE;
            end else if (sts.slot_empty) begin
               cmd.respond = 1'b1;
               if (sts.is_lookup) begin
                  cmd.status = ST_NOT_FOUND;
               end else if (sts.data_full) begin
                  cmd.status = ST_DATA_FULL;
               end else begin
                  cmd.status = ST_OK;
                  cmd.with_slot = 1'b1;
                  cmd.write_slot = 1'b1;
               end
               state_in = S_IDLE;
            end else if (sts.circle_done) begin
               cmd.respond = 1'b1;
               cmd.status = sts.is_lookup ? ST_NOT_FOUND : ST_INDEX_FULL;
               state_in = S_IDLE;
            end else begin
               cmd.advance = 1'b1;
               cmd.rd_issue = 1'b1;
               state_in = S_READ;
            end
         end
         S_CLEAR: begin
            if (sts.clr_done) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.write_slot |-> cmd.respond) else $error("write without response");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && start) |=> busy) else $error("start not taken");
   assert property (@(posedge clock) disable iff (reset)
      cmd.respond |=> !cmd.respond) else $error("double response");
endmodule

[design/lpht_dp.sv]
module lpht_dp #(
   parameter int MAX_SLOTS   = lpht_pkg::MAX_SLOTS_DEF,
   parameter int KEY_BYTES   = lpht_pkg::KEY_BYTES_DEF,
   parameter int VALUE_BYTES = lpht_pkg::VALUE_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lpht_pkg::cmd_type             cmd,
   output lpht_pkg::sts_type             sts,
   input  logic [lpht_pkg::OP_W-1:0]     req_operation,
   input  logic [lpht_pkg::KEYC_W-1:0]   req_key_chars,
   input  logic [lpht_pkg::KLEN_W-1:0]   req_key_length,
   input  logic [lpht_pkg::VAL_W-1:0]    req_value_in,
   input  logic [lpht_pkg::CAP_W-1:0]    index_capacity,
   input  logic [lpht_pkg::DCAP_W-1:0]   data_capacity,
   output logic                          rsp_valid,
   output logic [lpht_pkg::ST_W-1:0]     rsp_status,
   output logic [lpht_pkg::VAL_W-1:0]    rsp_value_out,
   output logic [lpht_pkg::SLOT_W-1:0]   rsp_slot_index
);
   import lpht_pkg::*;

   localparam int AW   = $clog2(MAX_SLOTS);
   localparam int CW   = AW + 1;
   localparam int KW   = KEY_BYTES * 8;
   localparam int VW   = VALUE_BYTES * 8;
   localparam int EW   = 1 + KLEN_W + KW;
   localparam int VCH  = (VALUE_BYTES + 3) / 4;
   localparam int CNTW = (CAP_W > CW) ? CAP_W : CW;

   logic [OP_W-1:0]   op_ff;
   logic [KW-1:0]     key_ff;
   logic [KLEN_W-1:0] len_ff;
   logic [VW-1:0]     val_ff;
   logic [HASH_W-1:0] hash_ff, hash_in;
   logic [KLEN_W-1:0] hcnt_ff;
   logic [CW-1:0]     cap_ff;
   logic [HASH_W-1:0] rem_ff;
   logic [5:0]        mbit_ff;
   logic              mbusy_ff;
   logic [AW-1:0]     idx_ff;
   logic [CW-1:0]     nprobe_ff;
   logic [DCAP_W-1:0] used_ff;
   logic [AW-1:0]     clr_ff;
   logic              clring_ff;
   logic [AW-1:0]     rd_addr;
   logic              ent_wr;
   logic [AW-1:0]     ent_addr;
   logic [EW-1:0]     ent_wdata, ent_rdata;
   logic [VW-1:0]     val_rdata;
   logic [KLEN_W-1:0] eff_len;
   logic [KW-1:0]     eff_key;
   logic [DCAP_W:0]   charge_sum;
   logic [CNTW-1:0]   cap_raw;
   logic [HASH_W:0]   rem_sh;

   always_comb begin
      eff_len = KLEN_W'(KEY_BYTES);
      if (req_key_length < KLEN_W'(KEY_BYTES)) eff_len = req_key_length;
      for (int i = KEY_BYTES - 1; i >= 0; i--) begin
         if (KLEN_W'(i) < eff_len && req_key_chars[i*8 +: 8] == 8'd0) eff_len = KLEN_W'(i);
      end
      for (int i = 0; i < KEY_BYTES; i++) begin
         eff_key[i*8 +: 8] = (KLEN_W'(i) < eff_len) ? req_key_chars[i*8 +: 8] : 8'd0;
      end
   end

   always_comb begin
      cap_raw = CNTW'(index_capacity);
      if (cap_raw == '0) cap_raw = CNTW'(1);
      if (cap_raw > CNTW'(MAX_SLOTS)) cap_raw = CNTW'(MAX_SLOTS);
   end

   assign hash_in = (hash_ff << 5) + HASH_W'(key_ff[hcnt_ff[$clog2(KEY_BYTES+1)-1:0]*8 +: 8]);
   assign rem_sh  = {rem_ff[HASH_W-1:0], 1'b0};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_operation;
         key_ff  <= eff_key;
         len_ff  <= eff_len;
         val_ff  <= req_value_in[VW-1:0];
         hash_ff <= '0;
         hcnt_ff <= '0;
         cap_ff  <= cap_raw[CW-1:0];
      end else if (cmd.hash_step) begin
         hash_ff <= hash_in;
         hcnt_ff <= hcnt_ff + 1'b1;
      end
      if (cmd.mod_start) begin
         rem_ff  <= '0;
         mbit_ff <= 6'd0;
      end else if (mbusy_ff) begin
         if ({1'b0, rem_sh[HASH_W-1:1], hash_ff[HASH_W-1-mbit_ff[4:0]]}
             >= (HASH_W+1)'(cap_ff))
            rem_ff <= HASH_W'({rem_sh[HASH_W-1:1], hash_ff[HASH_W-1-mbit_ff[4:0]]}
                   - HASH_W'(cap_ff));
         else
            rem_ff <= {rem_sh[HASH_W-1:1], hash_ff[HASH_W-1-mbit_ff[4:0]]};
         mbit_ff <= mbit_ff + 1'b1;
      end
      if (cmd.rd_issue && !cmd.advance) begin
         idx_ff    <= rem_ff[AW-1:0];
         nprobe_ff <= CW'(1);
      end else if (cmd.advance) begin
         idx_ff    <= (CW'(idx_ff) + 1'b1 == cap_ff) ? '0 : idx_ff + 1'b1;
         nprobe_ff <= nprobe_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mbusy_ff  <= 1'b0;
         used_ff   <= '0;
         clr_ff    <= '0;
         clring_ff <= 1'b1;
         rsp_valid <= 1'b0;
      end else begin
         if (cmd.mod_start) mbusy_ff <= 1'b1;
         else if (mbit_ff == 6'd31) mbusy_ff <= 1'b0;
         if (cmd.clr_start) begin
            clring_ff <= 1'b1;
            clr_ff    <= '0;
            used_ff   <= '0;
         end else if (clring_ff) begin
            clr_ff <= clr_ff + 1'b1;
            if (clr_ff == AW'(MAX_SLOTS - 1)) clring_ff <= 1'b0;
         end
         if (cmd.write_slot && ent_rdata[EW-1] == 1'b0)
            used_ff <= charge_sum[DCAP_W-1:0];
         rsp_valid <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_status     <= cmd.status;
         rsp_value_out  <= cmd.with_value ? VAL_W'(val_rdata) : '0;
         rsp_slot_index <= cmd.with_slot ? SLOT_W'(idx_ff) : '0;
      end
   end

   assign charge_sum = (DCAP_W+1)'(used_ff) + (DCAP_W+1)'((len_ff + 4'd4) >> 2)
                     + (DCAP_W+1)'(VCH);

   assign rd_addr   = idx_ff;
   assign ent_wr    = clring_ff || cmd.write_slot;
   assign ent_addr  = clring_ff ? clr_ff : idx_ff;
   assign ent_wdata = clring_ff ? '0 : {1'b1, len_ff, key_ff};

   lpht_ram #(.WIDTH(EW), .DEPTH(MAX_SLOTS)) u_entry (
      .clock(clock), .wr_en(ent_wr), .wr_addr(ent_addr), .wr_data(ent_wdata),
      .rd_addr(cmd.advance ? ((CW'(idx_ff) + 1'b1 == cap_ff) ? '0 : idx_ff + 1'b1)
                           : (cmd.rd_issue ? rem_ff[AW-1:0] : rd_addr)),
      .rd_data(ent_rdata));

   lpht_ram #(.WIDTH(VW), .DEPTH(MAX_SLOTS)) u_value (
      .clock(clock), .wr_en(cmd.write_slot), .wr_addr(idx_ff), .wr_data(val_ff),
      .rd_addr(cmd.advance ? ((CW'(idx_ff) + 1'b1 == cap_ff) ? '0 : idx_ff + 1'b1)
                           : (cmd.rd_issue ? rem_ff[AW-1:0] : rd_addr)),
      .rd_data(val_rdata));

   always_comb begin
      sts.is_insert   = (op_ff == OP_INSERT);
      sts.is_lookup   = (op_ff == OP_LOOKUP);
      sts.is_clear    = (op_ff == OP_CLEAR);
      sts.hash_done   = (hcnt_ff == len_ff);
      sts.mod_done    = !mbusy_ff && !cmd.mod_start && (mbit_ff == 6'd32);
      sts.clr_done    = !clring_ff;
      sts.slot_empty  = !ent_rdata[EW-1];
      sts.slot_match  = ent_rdata[EW-1] && ent_rdata[EW-2 -: KLEN_W] == len_ff
                        && ent_rdata[KW-1:0] == key_ff;
      sts.circle_done = (nprobe_ff == cap_ff);
      sts.data_full   = ({1'b0, data_capacity} <= charge_sum);
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.write_slot |-> !clring_ff) else $error("write during clear");
   assert property (@(posedge clock) disable iff (reset)
      cmd.advance |-> nprobe_ff < cap_ff) else $error("probe past circle");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_slot_index == '0) else $error("slot on fail");
endmodule

[design/linear_probe_hash_table_unit.sv]
// channel  | ports                                   | handshake
// request  | req_operation/key_chars/key_length/value_in | start & !busy
// response | rsp_status/value_out/slot_index         | rsp_valid, one cycle
// config   | csr_index/csr_data                      | csr_valid & csr_ready
// one item at a time: the hash takes one step per key byte, then the modulo
// takes one remainder bit a cycle, then each probed slot is read and then checked
// response strobe is registered from the deciding state; clear and ignored ops do not hash
// reset and a clear sweep every slot, one per cycle, with busy high
// the response strobe cannot be held off
module linear_probe_hash_table_unit #(
   parameter int MAX_SLOTS   = lpht_pkg::MAX_SLOTS_DEF,
   parameter int KEY_BYTES   = lpht_pkg::KEY_BYTES_DEF,
   parameter int VALUE_BYTES = lpht_pkg::VALUE_BYTES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [lpht_pkg::OP_W-1:0]   req_operation,
   input  logic [lpht_pkg::KEYC_W-1:0] req_key_chars,
   input  logic [lpht_pkg::KLEN_W-1:0] req_key_length,
   input  logic [lpht_pkg::VAL_W-1:0]  req_value_in,
   output logic                        rsp_valid,
   output logic [lpht_pkg::ST_W-1:0]   rsp_status,
   output logic [lpht_pkg::VAL_W-1:0]  rsp_value_out,
   output logic [lpht_pkg::SLOT_W-1:0] rsp_slot_index,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic                        csr_index,
   input  logic [lpht_pkg::DCAP_W-1:0] csr_data
);
   import lpht_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic [CAP_W-1:0]  icap_ff;
   logic [DCAP_W-1:0] dcap_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         icap_ff <= CAP_W'(1024);
         dcap_ff <= DCAP_W'(16384);
      end else if (csr_valid) begin
         if (csr_index == CSR_INDEX_CAP) icap_ff <= csr_data[CAP_W-1:0];
         else dcap_ff <= csr_data;
      end
   end

   lpht_ctrl u_ctrl (.clock(clock), .reset(reset), .start(start), .busy(busy),
      .cmd(cmd), .sts(sts));

   lpht_dp #(.MAX_SLOTS(MAX_SLOTS), .KEY_BYTES(KEY_BYTES), .VALUE_BYTES(VALUE_BYTES)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_operation(req_operation), .req_key_chars(req_key_chars),
      .req_key_length(req_key_length), .req_value_in(req_value_in),
      .index_capacity(icap_ff), .data_capacity(dcap_ff),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_value_out(rsp_value_out), .rsp_slot_index(rsp_slot_index));
endmodule

[tb/sv/tb.sv]
module tb;
   import lpht_pkg::*;

   localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
   localparam int SLOTS      = MAX_SLOTS_DEF;
   localparam int ITEM_GOAL  = 1650;
   localparam int IDLE_LIMIT = 40000;
   localparam int SCRIPT_LEN = 26;
   localparam bit ROW_ITEM = 1'b0;
   localparam bit ROW_CSR  = 1'b1;

   typedef struct packed {
      logic [ST_W-1:0]   status;
      logic [VAL_W-1:0]  value;
      logic [SLOT_W-1:0] slot;
   } outcome_type;

   // csr rows carry the register index in key_chars bit 0 and the data in value_in
   typedef struct packed {
      bit                kind;
      logic [OP_W-1:0]   op;
      logic [KEYC_W-1:0] key;
      logic [KLEN_W-1:0] len;
      logic [VAL_W-1:0]  val;
      bit                typed;
      outcome_type       want;
   } row_type;

   localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [OP_W-1:0]   req_operation  = '0;
   logic [KEYC_W-1:0] req_key_chars  = '0;
   logic [KLEN_W-1:0] req_key_length = '0;
   logic [VAL_W-1:0]  req_value_in   = '0;
   logic rsp_valid;
   logic [ST_W-1:0]   rsp_status;
   logic [VAL_W-1:0]  rsp_value_out;
   logic [SLOT_W-1:0] rsp_slot_index;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_index = 1'b0;
   logic [DCAP_W-1:0] csr_data = '0;

   linear_probe_hash_table_unit dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // predictor state
   bit          tbl_used [SLOTS];
   logic [63:0] tbl_key  [SLOTS];
   int          tbl_len  [SLOTS];
   logic [63:0] tbl_val  [SLOTS];
   int          budget_used;
   int          index_cap_reg;
   int          data_cap_reg;

   outcome_type pending_results[$];
   int errors, items_sent, results_seen, csr_writes, no_gaps;
   int status_count [4];
   int idle_cycles;

   row_type script [SCRIPT_LEN] = '{
      '{ROW_ITEM, OP_LOOKUP, 64'h61, 4'd1, 64'h0, 1, '{ST_NOT_FOUND, 64'h0, 10'd0}},
      '{ROW_ITEM, OP_INSERT, 64'h61, 4'd1, ONES, 1, '{ST_OK, 64'h0, 10'd97}},
      '{ROW_ITEM, OP_LOOKUP, 64'h61, 4'd1, 64'h0, 1, '{ST_OK, ONES, 10'd97}},
      '{ROW_ITEM, OP_INSERT, 64'h61, 4'd1, 64'h0123_4567_89AB_CDEF, 0, '0},
      '{ROW_ITEM, OP_LOOKUP, 64'h61, 4'd1, 64'h0, 0, '0},
      '{ROW_ITEM, OP_INSERT, ONES, 4'd15, 64'h5555_5555_5555_5555, 0, '0},
      '{ROW_ITEM, OP_LOOKUP, ONES, 4'd8, 64'h0, 0, '0},
      '{ROW_ITEM, OP_INSERT, 64'h41_0042, 4'd3, 64'hAAAA_AAAA_AAAA_AAAA, 0, '0},
      '{ROW_ITEM, OP_LOOKUP, 64'h42, 4'd1, 64'h0, 0, '0},
      '{ROW_ITEM, OP_INSERT, 64'h7F7F, 4'd0, 64'h1, 1, '{ST_OK, 64'h0, 10'd0}},
      '{ROW_ITEM, OP_LOOKUP, 64'h0, 4'd0, 64'h0, 0, '0},
      '{ROW_ITEM, OP_IGNORED, ONES, 4'd15, ONES, 1, '{ST_OK, 64'h0, 10'd0}},
      '{ROW_ITEM, OP_CLEAR, ONES, 4'd15, ONES, 1, '{ST_OK, 64'h0, 10'd0}},
      '{ROW_ITEM, OP_LOOKUP, 64'h61, 4'd1, 64'h0, 1, '{ST_NOT_FOUND, 64'h0, 10'd0}},
      '{ROW_CSR, OP_INSERT, 64'(CSR_DATA_CAP), 4'd0, 64'd0, 0, '0},
      '{ROW_ITEM, OP_INSERT, 64'h61, 4'd1, 64'h9, 1, '{ST_DATA_FULL, 64'h0, 10'd0}},
      '{ROW_CSR, OP_INSERT, 64'(CSR_DATA_CAP), 4'd0, 64'd32767, 0, '0},
      '{ROW_CSR, OP_INSERT, 64'(CSR_INDEX_CAP), 4'd0, 64'd0, 0, '0},
      '{ROW_ITEM, OP_INSERT, 64'h61, 4'd1, 64'h9, 1, '{ST_OK, 64'h0, 10'd0}},
      '{ROW_ITEM, OP_INSERT, 64'h62, 4'd1, 64'h9, 1, '{ST_INDEX_FULL, 64'h0, 10'd0}},
      '{ROW_ITEM, OP_LOOKUP, 64'h63, 4'd1, 64'h0, 1, '{ST_NOT_FOUND, 64'h0, 10'd0}},
      '{ROW_CSR, OP_INSERT, 64'(CSR_INDEX_CAP), 4'd0, 64'd2047, 0, '0},
      '{ROW_ITEM, OP_LOOKUP, 64'h61, 4'd1, 64'h0, 0, '0},
      '{ROW_ITEM, OP_CLEAR, 64'h0, 4'd0, 64'h0, 1, '{ST_OK, 64'h0, 10'd0}},
      '{ROW_CSR, OP_INSERT, 64'(CSR_INDEX_CAP), 4'd0, 64'd1024, 0, '0},
      '{ROW_CSR, OP_INSERT, 64'(CSR_DATA_CAP), 4'd0, 64'd16384, 0, '0}
   };

   function automatic outcome_type table_outcome(input logic [1:0] op, input logic [63:0] chars,
                                                 input logic [3:0] klen, input logic [63:0] val);
      outcome_type res;
      int len, cap, idx, n, charge, hit;
      logic [63:0] key;
      logic [31:0] h;
      res = '0;
      if (op == OP_CLEAR) begin
         foreach (tbl_used[i]) tbl_used[i] = 1'b0;
         budget_used = 0;
         return res;
      end
      if (op == OP_IGNORED) return res;
      len = (klen > KEY_BYTES_DEF) ? KEY_BYTES_DEF : int'(klen);
      n = 0;
      while (n < len && chars[n*8 +: 8] != 8'h00) n++;
      len = n;
      key = '0;
      for (int i = 0; i < len; i++) key[i*8 +: 8] = chars[i*8 +: 8];
      h = '0;
      for (int i = 0; i < len; i++) h = (h << 5) + 32'(key[i*8 +: 8]);
      cap = (index_cap_reg == 0) ? 1 : (index_cap_reg > SLOTS ? SLOTS : index_cap_reg);
      idx = int'(h % 32'(cap));
      hit = 2;
      for (n = 0; n < cap; n++) begin
         if (!tbl_used[idx]) begin
            hit = 1;
            break;
         end
         if (tbl_len[idx] == len && tbl_key[idx] == key) begin
            hit = 0;
            break;
         end
         idx = (idx + 1 == cap) ? 0 : idx + 1;
      end
      if (op == OP_INSERT) begin
         charge = (len + 4) / 4 + (VALUE_BYTES_DEF + 3) / 4;
         if (hit == 2) res.status = ST_INDEX_FULL;
         else if (hit == 0) begin
            tbl_val[idx] = val;
            res.slot = SLOT_W'(idx);
         end else if (data_cap_reg <= budget_used + charge) res.status = ST_DATA_FULL;
         else begin
            tbl_used[idx] = 1'b1;
            tbl_key[idx] = key;
            tbl_len[idx] = len;
            tbl_val[idx] = val;
            budget_used = (budget_used + charge) & 32'h7FFF;
            res.slot = SLOT_W'(idx);
         end
      end else if (hit == 0) begin
         res.value = tbl_val[idx];
         res.slot = SLOT_W'(idx);
      end else res.status = ST_NOT_FOUND;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      errors++;
      if (errors <= 30) $display("mismatch %s: got %h expected %h", what, got, want);
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid) begin
         results_seen++;
         status_count[rsp_status]++;
         if (pending_results.size() == 0) report_mismatch("unexpected beat", 64'(rsp_status), 0);
         else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", 64'(rsp_status), 64'(want.status));
            if (rsp_value_out !== want.value)
               report_mismatch("value_out", rsp_value_out, want.value);
            if (rsp_slot_index !== want.slot)
               report_mismatch("slot_index", 64'(rsp_slot_index), 64'(want.slot));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d cycles without a beat", idle_cycles);
         $display("linear_probe_hash_table_unit test failed");
         $finish;
      end
   end

   task automatic send_item(input logic [1:0] op, input logic [63:0] key, input logic [3:0] len,
                            input logic [63:0] val, input bit typed, input outcome_type want);
      int gap;
      outcome_type pred;
      gap = no_gaps ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_operation <= op;
      req_key_chars <= key;
      req_key_length <= len;
      req_value_in <= val;
      @(posedge clock);
      while (busy) @(posedge clock);
      pred = table_outcome(op, key, len, val);
      pending_results.push_back(typed ? want : pred);
      items_sent++;
   endtask

   task automatic drain;
      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic sel, input logic [DCAP_W-1:0] data);
      drain();
      csr_valid <= 1'b1;
      csr_index <= sel;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (sel == CSR_INDEX_CAP) index_cap_reg = int'(data) & 32'h7FF;
      else data_cap_reg = int'(data);
      csr_writes++;
      csr_valid <= 1'b0;
   endtask

   function automatic logic [63:0] rand_chars();
      logic [63:0] c;
      for (int i = 0; i < 8; i++)
         c[i*8 +: 8] = ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
      return c;
   endfunction

   initial begin
      logic [63:0] pool_key [24];
      logic [3:0]  pool_len [24];
      int pool_n, phase_len, pick, r;
      logic [1:0] op;
      logic [63:0] key;
      logic [3:0] len;
      logic [DCAP_W-1:0] icap, dcap;
      foreach (tbl_used[i]) begin
         tbl_used[i] = 1'b0;
         tbl_key[i] = '0;
         tbl_len[i] = 0;
         tbl_val[i] = '0;
      end
      budget_used = 0;
      index_cap_reg = 1024;
      data_cap_reg = 16384;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         if (script[i].kind == ROW_CSR) write_csr(script[i].key[0], DCAP_W'(script[i].val));
         else send_item(script[i].op, script[i].key, script[i].len, script[i].val,
                        script[i].typed, script[i].want);
      end

      while (items_sent < ITEM_GOAL) begin
         case ($urandom_range(0, 9))
            0: icap = 0;
            1: icap = 1;
            2: icap = 2;
            3: icap = 2047;
            4: icap = 1024;
            5: icap = DCAP_W'($urandom_range(0, 32767));
            default: icap = DCAP_W'($urandom_range(3, 64));
         endcase
         case ($urandom_range(0, 7))
            0: dcap = 0;
            1: dcap = 32767;
            2: dcap = 16384;
            3: dcap = DCAP_W'($urandom_range(0, 32767));
            default: dcap = DCAP_W'($urandom_range(3, 60));
         endcase
         write_csr(CSR_INDEX_CAP, icap);
         write_csr(CSR_DATA_CAP, dcap);
         no_gaps = ($urandom_range(0, 3) == 0);
         pool_n = $urandom_range(1, 24);
         for (int i = 0; i < pool_n; i++) begin
            pool_key[i] = rand_chars();
            pool_len[i] = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                      : 4'($urandom_range(1, 8));
         end
         phase_len = $urandom_range(20, 120);
         for (int k = 0; k < phase_len; k++) begin
            r = $urandom_range(0, 99);
            pick = $urandom_range(0, pool_n - 1);
            key = pool_key[pick];
            len = pool_len[pick];
            if (r >= 94) begin
               key = {$urandom, $urandom};
               len = 4'($urandom_range(0, 15));
            end
            if (r < 45) op = OP_INSERT;
            else if (r < 95) op = OP_LOOKUP;
            else if (r < 98) op = OP_CLEAR;
            else op = OP_IGNORED;
            send_item(op, key, len, {$urandom, $urandom}, 0, '0);
         end
      end

      drain();
      repeat (2200) @(posedge clock);
      $display("%0d requests, %0d responses, %0d register writes", items_sent, results_seen,
               csr_writes);
      $display("status ok %0d, not found %0d, index full %0d, data full %0d",
               status_count[0], status_count[1], status_count[2], status_count[3]);
      if (errors == 0 && pending_results.size() == 0)
         $display("linear_probe_hash_table_unit test passed");
      else
         $display("linear_probe_hash_table_unit test failed");
      $finish;
   end
endmodule

[filelist.f]
design/lpht_pkg.sv
design/lpht_ram.sv
design/lpht_ctrl.sv
design/lpht_dp.sv
design/linear_probe_hash_table_unit.sv
tb/sv/tb.sv
